FILE: rtl/hnc_pkg.sv
// Shared constants, payload types and helper functions of the nearest-codeword search.
package hnc_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int DESC_BITS   = 256;
	localparam int VEC_WORDS   = (DESC_BITS + 63) / 64;
	localparam int TOP_BITS    = DESC_BITS - 64 * (VEC_WORDS - 1);
	localparam int ENT_W       = 10;
	localparam int WRD_W       = 2;
	localparam int CFG_W       = 11;
	localparam int ID_W        = 16;
	localparam int CW_DEPTH    = MAX_ENTRIES * VEC_WORDS;
	localparam int CW_AW       = $clog2(CW_DEPTH);
	localparam int DIST_W      = $clog2(DESC_BITS + 1);
	localparam int PADDR_W     = 3;

	localparam logic [7:0] DIST_CLIP = 8'd255;
	localparam logic [PADDR_W-3:0] REG_ENTRIES_IN_USE = '0;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [ENT_W-1:0]  entry_index;
		logic [WRD_W-1:0]  word_index;
		logic [63:0]       vector_word;
		logic [ID_W-1:0]   entry_id;
		logic              query_last;
	} in_word_t;

	typedef struct packed {
		logic [ID_W-1:0] best_id;
		logic [7:0]      best_distance;
		logic            found;
	} out_word_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} ctl_t;

	function automatic logic [63:0] word_mask(input logic [WRD_W-1:0] w);
		logic [63:0] m;
		if ((int'(w) + 1 < VEC_WORDS) || (TOP_BITS >= 64)) begin
			m = '1;
		end else begin
			m = (64'd1 << (TOP_BITS % 64)) - 64'd1;
		end
		return m;
	endfunction

	function automatic logic [3:0] byte_count(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(b[i]);
		end
		return n;
	endfunction

endpackage

FILE: rtl/hnc_match.sv
// Distance pipeline: per-word bit count, per-entry accumulation and best-match tracking.
module hnc_match import hnc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clear,
	input  ctl_t            ctl_in,
	input  logic [63:0]     diff,
	input  logic [ID_W-1:0] id_in,
	output logic            busy,
	output out_word_t       best
);

	ctl_t            ctl_s2;
	logic [3:0]      bytes_s2 [8];
	logic [ID_W-1:0] id_s2;
	ctl_t            ctl_s3;
	logic [6:0]      wcnt_s3;
	logic [ID_W-1:0] id_s3;

	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] best_d_q;
	logic [ID_W-1:0]   best_id_q;
	logic              any_q;

	logic [3:0]        bytes_d [8];
	logic [6:0]        wcnt_d;
	logic [DIST_W-1:0] acc_d;
	logic              better;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			bytes_d[i] = byte_count(diff[8*i +: 8]);
		end
	end

	always_comb begin
		wcnt_d = '0;
		for (int i = 0; i < 8; i++) begin
			wcnt_d = wcnt_d + 7'(bytes_s2[i]);
		end
	end

	always_comb begin
		acc_d = (ctl_s3.first ? '0 : acc_q) + DIST_W'(wcnt_s3);
		better = !any_q || (acc_d < best_d_q) || ((acc_d == best_d_q) && (id_s3 > best_id_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			any_q  <= 1'b0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			if (clear) begin
				any_q <= 1'b0;
			end else if (ctl_s3.valid && ctl_s3.last && better) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		bytes_s2 <= bytes_d;
		id_s2    <= id_in;
		wcnt_s3  <= wcnt_d;
		id_s3    <= id_s2;
		if (ctl_s3.valid) begin
			acc_q <= acc_d;
			if (ctl_s3.last && better) begin
				best_d_q  <= acc_d;
				best_id_q <= id_s3;
			end
		end
	end

	assign busy = ctl_s2.valid | ctl_s3.valid;

	always_comb begin
		best.found = any_q;
		if (!any_q) begin
			best.best_id       = '0;
			best.best_distance = DIST_CLIP;
		end else begin
			best.best_id = best_id_q;
			if (int'(best_d_q) > int'(DIST_CLIP)) begin
				best.best_distance = DIST_CLIP;
			end else begin
				best.best_distance = 8'(best_d_q);
			end
		end
	end

endmodule

FILE: rtl/hamming_nearest_codeword.sv
// Top level of the Hamming nearest-codeword search: codebook memories, sequencer and ports.
//
// Input words arrive on in_valid/in_ready with an in_word_t payload. A load word
// (op = load) writes one 64-bit word of a codebook entry and that entry's ID. A
// query word fills one word of the query buffer; a query word with query_last set
// starts a search over the first entries_in_use entries, capped at 1024.
// The search reads the codeword memory, through its single read port, one 64-bit
// word per cycle. No input word is taken from the final query word until the
// search result enters the output register.
// The result leaves on out_valid/out_ready as an out_word_t. A result that waits
// for the receiver does not block load or query words; a second search holds its
// result until the output register is free.
// entries_in_use is written through the APB port while paddr[2] is low (byte addresses 0 to 3).
// Reset clears the sequencer, the output valid flag and entries_in_use. The
// codebook and query buffer are undefined until written; no clearing pass runs.
module hamming_nearest_codeword import hnc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	state_t state_q, state_d;

	logic [CFG_W-1:0] entries_q;
	logic [CFG_W-1:0] n_eff;
	logic [CFG_W-1:0] ent_q;
	logic [WRD_W-1:0] wrd_q;

	logic in_acc, start, issue, load_out;
	logic cw_we;
	logic [CW_AW-1:0] cw_waddr, cw_raddr;

	logic [63:0]     cw_mem [CW_DEPTH];
	logic [ID_W-1:0] id_mem [MAX_ENTRIES];
	logic [63:0]     qbuf_q [VEC_WORDS];

	ctl_t            ctl_s1;
	logic [63:0]     rd_s1;
	logic [63:0]     q_s1;
	logic [63:0]     mask_s1;
	logic [ID_W-1:0] id_s1;

	logic      busy;
	out_word_t best;
	logic      out_valid_q;
	out_word_t out_word_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE)) begin
			entries_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE) ? 32'(entries_q) : '0;
	assign n_eff  = (int'(entries_q) > MAX_ENTRIES) ? CFG_W'(MAX_ENTRIES) : entries_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign start    = in_acc && (in_word.op == OP_QUERY) && in_word.query_last;
	assign issue    = (state_q == ST_SEARCH) && (ent_q < n_eff);

	assign cw_we = in_acc && (in_word.op == OP_LOAD) && (int'(in_word.entry_index) < MAX_ENTRIES)
		&& (int'(in_word.word_index) < VEC_WORDS);
	assign cw_waddr = CW_AW'(in_word.entry_index) * CW_AW'(VEC_WORDS) + CW_AW'(in_word.word_index);
	assign cw_raddr = CW_AW'(ent_q[ENT_W-1:0]) * CW_AW'(VEC_WORDS) + CW_AW'(wrd_q);

	always_ff @(posedge clk) begin
		if (cw_we) begin
			cw_mem[cw_waddr] <= in_word.vector_word;
		end
		if (issue) begin
			rd_s1 <= cw_mem[cw_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_word.op == OP_LOAD) && (int'(in_word.entry_index) < MAX_ENTRIES)) begin
			id_mem[in_word.entry_index] <= in_word.entry_id;
		end
		if (issue) begin
			id_s1 <= id_mem[ent_q[ENT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_word.op == OP_QUERY) && (int'(in_word.word_index) < VEC_WORDS)) begin
			qbuf_q[in_word.word_index] <= in_word.vector_word;
		end
		if (issue) begin
			q_s1    <= qbuf_q[wrd_q];
			mask_s1 <= word_mask(wrd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q   <= '0;
			wrd_q   <= '0;
			ctl_s1  <= '0;
		end else begin
			state_q      <= state_d;
			ctl_s1.valid <= issue;
			ctl_s1.first <= (wrd_q == '0);
			ctl_s1.last  <= (int'(wrd_q) == VEC_WORDS - 1);
			if (start) begin
				ent_q <= '0;
				wrd_q <= '0;
			end else if (issue) begin
				if (int'(wrd_q) == VEC_WORDS - 1) begin
					wrd_q <= '0;
					ent_q <= ent_q + CFG_W'(1);
				end else begin
					wrd_q <= wrd_q + WRD_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!ctl_s1.valid && !busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	hnc_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (start),
		.ctl_in (ctl_s1),
		.diff   ((rd_s1 ^ q_s1) & mask_s1),
		.id_in  (id_s1),
		.busy   (busy),
		.best   (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= best;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef NO_ASSERTIONS
	a_start_search: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_SEARCH) && (ent_q == '0) && (wrd_q == '0))
		else $error("Final query word did not start a search from entry zero.");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> (!ctl_s1.valid && !busy))
		else $error("Result taken while the distance pipeline still held words.");

	a_reads_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |-> ((state_q == ST_SEARCH) || (state_q == ST_DRAIN)))
		else $error("Codeword read outside a search.");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.found) |-> ((out_word.best_distance == DIST_CLIP)
			&& (out_word.best_id == '0)))
		else $error("Empty search returned a wrong distance or ID.");
`endif

endmodule
